// ===== rtl/mabc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mabc_pkg: shared types and constants for the Morton alpha blend compositor
// Holds the store geometry, the item kind codes, the queued command record
// and the Morton address function used by the front end.
// ----------------------------------------------------------------------------
package mabc_pkg;

    // Coordinate bits that take part in the Z-order address (4 to 12).
    localparam int COORD_BITS = 9;
    // Fixed width of the x and y ports.
    localparam int IN_COORD_W = 9;
    localparam int ADDR_BITS  = 2 * COORD_BITS;
    localparam int PIX_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int KIND_W     = 2;

    // Command queue between front and back; depth must be a power of two.
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        K_WRITE = 2'd0,
        K_BLEND = 2'd1,
        K_READ  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [ADDR_BITS-1:0] addr;
        logic [PIX_W-1:0]     pixel;
    } t_cmd;

    // Front-to-back command offer.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_req;

    // Interleave x into the even and y into the odd address bits.
    function automatic logic [ADDR_BITS-1:0] morton_addr(
        input logic [IN_COORD_W-1:0] x,
        input logic [IN_COORD_W-1:0] y
    );
        logic [COORD_BITS-1:0] xc;
        logic [COORD_BITS-1:0] yc;
        logic [ADDR_BITS-1:0]  addr;
        xc = COORD_BITS'(x);
        yc = COORD_BITS'(y);
        for (int b = 0; b < COORD_BITS; b++) begin
            addr[2*b]     = xc[b];
            addr[2*b + 1] = yc[b];
        end
        return addr;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mabc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mabc_front: item intake, classification and command queue
// Accepts items, drops the unused kind, forms the Morton address and holds
// the resulting commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module mabc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic [mabc_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [mabc_pkg::IN_COORD_W-1:0] i_x,
    input  wire logic [mabc_pkg::IN_COORD_W-1:0] i_y,
    input  wire logic [mabc_pkg::PIX_W-1:0]    i_pixel,
    output mabc_pkg::t_cmd_req                 o_req,
    input  wire logic                          i_take
);
    import mabc_pkg::*;

    t_cmd                 r_q [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count,  n_count;
    logic                 accept;
    logic                 enq;
    logic                 deq;
    logic                 known_kind;
    t_cmd                 new_cmd;

    assign o_full = (r_count == QCNT_BITS'(QDEPTH));
    assign accept = i_push && !o_full;

    // Kind 3 has no meaning: it is accepted and then dropped.
    assign known_kind = i_kind inside {K_WRITE, K_BLEND, K_READ};
    assign enq        = accept && known_kind;
    assign deq        = o_req.valid && i_take;

    always_comb begin
        new_cmd.kind  = t_kind'(i_kind);
        new_cmd.addr  = morton_addr(i_x, i_y);
        new_cmd.pixel = i_pixel;
    end

    assign o_req.valid = (r_count != '0);
    assign o_req.cmd   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_BITS'(enq);
        n_rd_ptr = r_rd_ptr + QPTR_BITS'(deq);
        n_count  = r_count + QCNT_BITS'(enq) - QCNT_BITS'(deq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= new_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mabc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mabc_back: pixel store, blend datapath and result register
// Takes one command at a time from the queue, performs the store access or
// the read-modify-write blend, and presents read results to the output.
// ----------------------------------------------------------------------------
module mabc_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mabc_pkg::t_cmd_req         i_req,
    output logic                            o_take,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output logic [mabc_pkg::PIX_W-1:0]      o_read_data
);
    import mabc_pkg::*;

    localparam int STORE_WORDS = 1 << ADDR_BITS;
    localparam int SUM_W       = 2 * CHAN_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOOK  = 3'b010,
        S_STORE = 3'b100
    } t_bstate;

    logic [PIX_W-1:0]     r_store [STORE_WORDS];
    logic [PIX_W-1:0]     r_rdata;
    t_bstate              r_state, n_state;
    t_cmd                 r_cmd;
    logic [SUM_W-1:0]     r_sum [NUM_CHAN];
    logic [SUM_W-1:0]     n_sum [NUM_CHAN];
    logic                 r_out_valid, n_out_valid;
    logic [PIX_W-1:0]     r_out_data,  n_out_data;
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [PIX_W-1:0]     wdata;
    logic                 re;
    logic [CHAN_W-1:0]    alpha;
    logic [CHAN_W-1:0]    quot [NUM_CHAN];

    // Exact division by 255 for values below 65280.
    function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] t;
        t = v + SUM_W'(1) + (v >> CHAN_W);
        return t[SUM_W-1:CHAN_W];
    endfunction

    // A read is only started when the result register is free.
    assign o_take = (r_state == S_IDLE) && i_req.valid &&
                    ((i_req.cmd.kind != K_READ) || !r_out_valid);

    assign alpha = r_cmd.pixel[PIX_W-1 -: CHAN_W];

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            n_sum[c] = SUM_W'(r_cmd.pixel[c*CHAN_W +: CHAN_W]) * SUM_W'(alpha)
                     + SUM_W'(r_rdata[c*CHAN_W +: CHAN_W]) * SUM_W'(CHAN_W'(255) - alpha)
                     + SUM_W'(127);
            quot[c]  = div255(r_sum[c]);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        we          = 1'b0;
        re          = 1'b0;
        waddr       = r_cmd.addr;
        wdata       = {CHAN_W'(255), quot[2], quot[1], quot[0]};
        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (o_take) begin
                    if (i_req.cmd.kind == K_WRITE) begin
                        we    = 1'b1;
                        waddr = i_req.cmd.addr;
                        wdata = i_req.cmd.pixel;
                    end else begin
                        re      = 1'b1;
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (r_cmd.kind == K_READ) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rdata;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                we      = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (o_take) begin
            r_cmd <= i_req.cmd;
        end
        if (r_state == S_LOOK) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_store[i_req.cmd.addr];
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_read_data = r_out_data;

endmodule
`default_nettype wire

// ===== rtl/morton_alpha_blend_compositor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// morton_alpha_blend_compositor: Z-order pixel store with source-over blend
// Stores 32-bit pixels at Morton addresses, blends overlay pixels onto the
// stored ones and returns stored pixels on request.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload                        Direction
//  input     i_push / o_full    i_kind, i_x, i_y, i_pixel      into block
//  result    o_empty / i_pop    o_read_data                    out of block
//
//  An item enters a four-entry command queue in the cycle it is accepted.
//  The back end then performs a base write directly, a read in two steps (store
//  read port, then result register) and a blend in three (store read,
//  products, divide and write back); it works on one command at a time,
//  so the next command waits until the last one is through.
//  Reset (i_rst_n low, synchronous) empties the queue and the result
//  register; the pixel store keeps its contents and needs no clearing.
//  A waiting result holds back the next read at the head of the queue and
//  every command queued behind it; commands ahead of that read go on.
//
module morton_alpha_blend_compositor (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    output logic                                 o_full,
    input  wire logic [mabc_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [mabc_pkg::IN_COORD_W-1:0] i_x,
    input  wire logic [mabc_pkg::IN_COORD_W-1:0] i_y,
    input  wire logic [mabc_pkg::PIX_W-1:0]      i_pixel,
    output logic                                 o_empty,
    input  wire logic                            i_pop,
    output logic [mabc_pkg::PIX_W-1:0]           o_read_data
);
    import mabc_pkg::*;

    // Command offer from the front end and the back end's acceptance of it.
    t_cmd_req req;
    logic     take;

    // The front end classifies each item and queues it as a command with
    // its Morton address already formed.
    mabc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_kind  (i_kind),
        .i_x     (i_x),
        .i_y     (i_y),
        .i_pixel (i_pixel),
        .o_req   (req),
        .i_take  (take)
    );

    // The back end owns the pixel store and the result register.
    mabc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_take      (take),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_read_data (o_read_data)
    );

    // The queue can only fill up on the edge after an accepted item.
    a_full_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_full) |-> $past(i_push && !o_full))
        else $error("queue became full without an accepted item");

    // A result only goes away when it is taken.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_empty) |-> $past(i_pop))
        else $error("result dropped without a pop");

    // The back end never takes a command the queue does not offer.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> req.valid)
        else $error("command taken from an empty queue");

endmodule
`default_nettype wire
